>>> rtl/glqs_pkg.sv
package glqs_pkg;

  // Fixed field widths of the block's ports
  localparam int IDX_W   = 6;
  localparam int NODE_W  = 5;
  localparam int ARR_W   = 64;
  localparam int CNT_W   = 7;
  localparam int TOTAL_W = 22;
  localparam int CFG_W   = 7;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Operation codes of an input transaction
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SLOT = 1'b1;

  // Modes of the shared per-link unit
  typedef enum logic {
    ALU_SCAN,
    ALU_SERVE
  } alu_mode_t;

  // Endpoint pair of one link
  typedef struct packed {
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
  } ends_t;

  // Per-link control into the shared unit
  typedef struct packed {
    alu_mode_t mode;
    logic      first;
    logic      arr_bit;
    logic      cand_bit;
    logic      have_b;
    logic      is_b;
    logic      sched_bit;
    logic      nb_found;
  } alu_ctl_t;

  // Per-link decisions out of the shared unit
  typedef struct packed {
    logic q_we;
    logic drop;
    logic keep;
    logic better;
    logic served;
  } alu_flags_t;

endpackage

>>> rtl/glqs_ram.sv
module glqs_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/glqs_alu.sv
module glqs_alu
  import glqs_pkg::*;
#(
  parameter int QUEUE_BITS = 16
) (
  input  alu_ctl_t              ctl,
  input  logic [QUEUE_BITS-1:0] q,
  input  ends_t                 ends,
  input  ends_t                 b_ends,
  input  logic [QUEUE_BITS-1:0] nb_q,
  input  logic [TOTAL_W-1:0]    sum_in,
  output alu_flags_t            flags,
  output logic [QUEUE_BITS-1:0] q_new,
  output logic [TOTAL_W-1:0]    sum_out
);

  localparam int SW = ((QUEUE_BITS > TOTAL_W) ? QUEUE_BITS : TOTAL_W) + 1;

  logic          q_full;
  logic          share;
  logic          inc;
  logic          dec;
  logic          elim;
  logic [SW-1:0] wide;

  assign q_full = &q;
  assign share  = (ends.a == b_ends.a) || (ends.a == b_ends.b) ||
                  (ends.b == b_ends.a) || (ends.b == b_ends.b);

  // Update one link's count and judge it as a candidate or a server
  always_comb begin
    flags   = '0;
    q_new   = q;
    sum_out = sum_in;
    inc     = 1'b0;
    dec     = 1'b0;
    elim    = 1'b0;
    wide    = '0;
    case (ctl.mode)
      ALU_SCAN: begin
        inc          = ctl.first & ctl.arr_bit;
        q_new        = (inc && !q_full) ? q + QUEUE_BITS'(1) : q;
        flags.q_we   = inc & ~q_full;
        flags.drop   = inc & q_full;
        elim         = ctl.have_b & (ctl.is_b | share);
        flags.keep   = (ctl.first | ctl.cand_bit) & ~elim;
        flags.better = flags.keep & (~ctl.nb_found | (q_new > nb_q));
      end
      ALU_SERVE: begin
        dec          = ctl.sched_bit & (q != '0);
        q_new        = dec ? q - QUEUE_BITS'(1) : q;
        flags.q_we   = dec;
        flags.served = dec;
        wide         = SW'(sum_in) + SW'(q_new);
        sum_out      = (wide > SW'(TOTAL_MAX)) ? TOTAL_MAX : wide[TOTAL_W-1:0];
      end
      default: begin
        flags = '0;
      end
    endcase
  end

endmodule

>>> rtl/greedy_longest_queue_link_scheduler_core.sv
// Greedy longest-queue-first link scheduler under node-exclusive interference.
// Input: a transaction is taken when start is high and busy is low. op = load
//   writes the endpoints of one link; op = slot adds the arrival mask to the
//   link counts and builds one schedule. Busy stays high until the result.
// Result: out_valid strobes for one cycle with schedule, served count,
//   queue total and drops; the receiver cannot hold it off.
// Config: cfg_num_links is written when cfg_valid is high (cfg_ready is
//   always high); write it only while busy is low.
// Passes, with k links scheduled: every pass walks the links in use through
//   one shared compare/add unit at one link a cycle, reading the count
//   memory. A slot takes k+1 scan passes and one service pass; a load takes
//   one summing pass. The result strobes in the first cycle with busy low,
//   and a new transaction may start in that cycle.
// Reset: counts read as zero via per-link valid bits, num_links is zero and
//   endpoints are undefined until loaded. No clearing pass is needed.
module greedy_longest_queue_link_scheduler_core
  import glqs_pkg::*;
#(
  parameter int MAX_LINKS  = 64,
  parameter int QUEUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_op,
  input  logic [IDX_W-1:0]      in_link_index,
  input  logic [NODE_W-1:0]     in_node_a,
  input  logic [NODE_W-1:0]     in_node_b,
  input  logic [ARR_W-1:0]      in_arrivals,
  output logic                  out_valid,
  output logic [ARR_W-1:0]      out_schedule,
  output logic [CNT_W-1:0]      out_served_count,
  output logic [TOTAL_W-1:0]    out_total_queued,
  output logic [CNT_W-1:0]      out_dropped,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_num_links
);

  localparam int LW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
  localparam int CW = $clog2(MAX_LINKS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SERVE
  } state_t;

  state_t                state_r, state_nxt;
  logic [CFG_W-1:0]      num_links_r, num_links_nxt;
  logic [CW-1:0]         rd_i_r, rd_i_nxt;
  logic                  p_vld_r, p_vld_nxt;
  logic [LW-1:0]         p_idx_r, p_idx_nxt;
  logic                  p_qv_r, p_qv_nxt;
  logic [MAX_LINKS-1:0]  qv_r, qv_nxt;
  logic                  first_r, first_nxt;
  logic [MAX_LINKS-1:0]  cand_r, cand_nxt;
  logic [MAX_LINKS-1:0]  sched_r, sched_nxt;
  logic [MAX_LINKS-1:0]  arr_r, arr_nxt;
  logic                  have_b_r, have_b_nxt;
  logic [LW-1:0]         b_idx_r, b_idx_nxt;
  ends_t                 b_ends_r, b_ends_nxt;
  logic                  nb_found_r, nb_found_nxt;
  logic [LW-1:0]         nb_idx_r, nb_idx_nxt;
  logic [QUEUE_BITS-1:0] nb_q_r, nb_q_nxt;
  ends_t                 nb_ends_r, nb_ends_nxt;
  logic [CNT_W-1:0]      served_r, served_nxt;
  logic [CNT_W-1:0]      drop_r, drop_nxt;
  logic [TOTAL_W-1:0]    sum_r, sum_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ARR_W-1:0]      out_schedule_r, out_schedule_nxt;
  logic [CNT_W-1:0]      out_served_count_r, out_served_count_nxt;
  logic [TOTAL_W-1:0]    out_total_queued_r, out_total_queued_nxt;
  logic [CNT_W-1:0]      out_dropped_r, out_dropped_nxt;

  logic                  accept;
  logic [CW-1:0]         n_links;
  logic                  in_pass;
  logic                  issuing;
  logic                  pass_end;
  logic [LW-1:0]         rd_addr;
  logic                  q_we;
  logic [QUEUE_BITS-1:0] q_rdata;
  logic [QUEUE_BITS-1:0] q_cur;
  logic                  ep_we;
  ends_t                 ep_wdata;
  ends_t                 ep_rdata;
  alu_ctl_t              alu_ctl;
  alu_flags_t            alu_flags;
  logic [QUEUE_BITS-1:0] alu_q_new;
  logic [TOTAL_W-1:0]    alu_sum;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;

  assign out_valid        = out_valid_r;
  assign out_schedule     = out_schedule_r;
  assign out_served_count = out_served_count_r;
  assign out_total_queued = out_total_queued_r;
  assign out_dropped      = out_dropped_r;

  // Clamp the link count to the storage depth
  assign n_links = (num_links_r > CFG_W'(MAX_LINKS)) ? CW'(MAX_LINKS)
                                                      : num_links_r[CW-1:0];

  // Walk the links: issue a read, process the returned data in the next cycle
  assign in_pass  = (state_r == ST_SCAN) || (state_r == ST_SERVE);
  assign issuing  = in_pass && (rd_i_r < n_links);
  assign pass_end = in_pass && !issuing && !p_vld_r;
  assign rd_addr  = rd_i_r[LW-1:0];

  // Count store, reads as zero until written
  glqs_ram #(
    .DEPTH (MAX_LINKS),
    .WIDTH (QUEUE_BITS),
    .AW    (LW)
  ) u_q_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (p_idx_r),
    .wdata (alu_q_new),
    .raddr (rd_addr),
    .rdata (q_rdata)
  );

  assign q_cur = p_qv_r ? q_rdata : '0;
  assign q_we  = p_vld_r & alu_flags.q_we;

  // Endpoint store, written by load transactions
  assign ep_we      = accept && (in_op == OP_LOAD) &&
                      ((CFG_W'(in_link_index)) < CFG_W'(MAX_LINKS));
  assign ep_wdata.a = in_node_a;
  assign ep_wdata.b = in_node_b;

  glqs_ram #(
    .DEPTH (MAX_LINKS),
    .WIDTH (2 * NODE_W),
    .AW    (LW)
  ) u_ep_ram (
    .clk   (clk),
    .we    (ep_we),
    .waddr (in_link_index[LW-1:0]),
    .wdata (ep_wdata),
    .raddr (rd_addr),
    .rdata (ep_rdata)
  );

  // Shared per-link unit
  always_comb begin
    alu_ctl.mode      = (state_r == ST_SERVE) ? ALU_SERVE : ALU_SCAN;
    alu_ctl.first     = first_r;
    alu_ctl.arr_bit   = arr_r[p_idx_r];
    alu_ctl.cand_bit  = cand_r[p_idx_r];
    alu_ctl.have_b    = have_b_r;
    alu_ctl.is_b      = (p_idx_r == b_idx_r);
    alu_ctl.sched_bit = sched_r[p_idx_r];
    alu_ctl.nb_found  = nb_found_r;
  end

  glqs_alu #(
    .QUEUE_BITS (QUEUE_BITS)
  ) u_alu (
    .ctl     (alu_ctl),
    .q       (q_cur),
    .ends    (ep_rdata),
    .b_ends  (b_ends_r),
    .nb_q    (nb_q_r),
    .sum_in  (sum_r),
    .flags   (alu_flags),
    .q_new   (alu_q_new),
    .sum_out (alu_sum)
  );

  // Sequencer: accept, scan rounds, service pass, result
  always_comb begin
    state_nxt            = state_r;
    num_links_nxt        = cfg_valid ? cfg_num_links : num_links_r;
    rd_i_nxt             = issuing ? rd_i_r + CW'(1) : rd_i_r;
    p_vld_nxt            = issuing;
    p_idx_nxt            = rd_addr;
    p_qv_nxt             = qv_r[rd_addr];
    qv_nxt               = qv_r;
    first_nxt            = first_r;
    cand_nxt             = cand_r;
    sched_nxt            = sched_r;
    arr_nxt              = arr_r;
    have_b_nxt           = have_b_r;
    b_idx_nxt            = b_idx_r;
    b_ends_nxt           = b_ends_r;
    nb_found_nxt         = nb_found_r;
    nb_idx_nxt           = nb_idx_r;
    nb_q_nxt             = nb_q_r;
    nb_ends_nxt          = nb_ends_r;
    served_nxt           = served_r;
    drop_nxt             = drop_r;
    sum_nxt              = sum_r;
    out_valid_nxt        = 1'b0;
    out_schedule_nxt     = out_schedule_r;
    out_served_count_nxt = out_served_count_r;
    out_total_queued_nxt = out_total_queued_r;
    out_dropped_nxt      = out_dropped_r;

    // Mark written counts as valid
    if (q_we) begin
      qv_nxt[p_idx_r] = 1'b1;
    end

    // Take a new transaction
    if (accept) begin
      rd_i_nxt   = '0;
      sched_nxt  = '0;
      served_nxt = '0;
      drop_nxt   = '0;
      sum_nxt    = '0;
      case (in_op)
        OP_LOAD: begin
          state_nxt = ST_SERVE;
        end
        OP_SLOT: begin
          state_nxt    = ST_SCAN;
          first_nxt    = 1'b1;
          cand_nxt     = '0;
          have_b_nxt   = 1'b0;
          nb_found_nxt = 1'b0;
          arr_nxt      = in_arrivals[MAX_LINKS-1:0];
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end

    // Process the link whose data has returned
    if (p_vld_r) begin
      case (state_r)
        ST_SCAN: begin
          if (alu_flags.drop) begin
            drop_nxt = drop_r + CNT_W'(1);
          end
          cand_nxt[p_idx_r] = alu_flags.keep;
          if (alu_flags.better) begin
            nb_found_nxt = 1'b1;
            nb_idx_nxt   = p_idx_r;
            nb_q_nxt     = alu_q_new;
            nb_ends_nxt  = ep_rdata;
          end
        end
        ST_SERVE: begin
          if (alu_flags.served) begin
            served_nxt = served_r + CNT_W'(1);
          end
          sum_nxt = alu_sum;
        end
        default: begin
          sum_nxt = sum_r;
        end
      endcase
    end

    // Close a pass: schedule the round winner or move on
    if (pass_end) begin
      rd_i_nxt = '0;
      case (state_r)
        ST_SCAN: begin
          if (nb_found_r) begin
            sched_nxt[nb_idx_r] = 1'b1;
            have_b_nxt          = 1'b1;
            b_idx_nxt           = nb_idx_r;
            b_ends_nxt          = nb_ends_r;
            nb_found_nxt        = 1'b0;
            first_nxt           = 1'b0;
          end else begin
            state_nxt = ST_SERVE;
            sum_nxt   = '0;
          end
        end
        ST_SERVE: begin
          state_nxt            = ST_IDLE;
          out_valid_nxt        = 1'b1;
          out_schedule_nxt     = ARR_W'(sched_r);
          out_served_count_nxt = served_r;
          out_total_queued_nxt = sum_r;
          out_dropped_nxt      = drop_r;
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      num_links_r <= '0;
      p_vld_r     <= 1'b0;
      qv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      num_links_r <= num_links_nxt;
      p_vld_r     <= p_vld_nxt;
      qv_r        <= qv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_i_r             <= rd_i_nxt;
    p_idx_r            <= p_idx_nxt;
    p_qv_r             <= p_qv_nxt;
    first_r            <= first_nxt;
    cand_r             <= cand_nxt;
    sched_r            <= sched_nxt;
    arr_r              <= arr_nxt;
    have_b_r           <= have_b_nxt;
    b_idx_r            <= b_idx_nxt;
    b_ends_r           <= b_ends_nxt;
    nb_found_r         <= nb_found_nxt;
    nb_idx_r           <= nb_idx_nxt;
    nb_q_r             <= nb_q_nxt;
    nb_ends_r          <= nb_ends_nxt;
    served_r           <= served_nxt;
    drop_r             <= drop_nxt;
    sum_r              <= sum_nxt;
    out_schedule_r     <= out_schedule_nxt;
    out_served_count_r <= out_served_count_nxt;
    out_total_queued_r <= out_total_queued_nxt;
    out_dropped_r      <= out_dropped_nxt;
  end

`ifndef SYNTHESIS
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");

  a_served_le_sched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_served_count_r <= CNT_W'($countones(out_schedule_r))))
    else $error("more links served than scheduled");

  a_qwe_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    q_we |-> ((state_r == ST_SCAN) || (state_r == ST_SERVE)))
    else $error("count store written outside a pass");

  a_idle_no_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !p_vld_r)
    else $error("link read still in flight while idle");
`endif

endmodule

>>> bench/glqs_checker.sv
module glqs_checker
  import glqs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_op,
  input  logic [IDX_W-1:0]   in_link_index,
  input  logic [NODE_W-1:0]  in_node_a,
  input  logic [NODE_W-1:0]  in_node_b,
  input  logic [ARR_W-1:0]   in_arrivals,
  input  logic               out_valid,
  input  logic [ARR_W-1:0]   out_schedule,
  input  logic [CNT_W-1:0]   out_served_count,
  input  logic [TOTAL_W-1:0] out_total_queued,
  input  logic [CNT_W-1:0]   out_dropped,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_num_links,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINKS = 64;
  localparam int QBITS = 16;
  localparam int SLOTS = 4;
  localparam logic [QBITS-1:0] QUEUE_FULL = '1;

  // One result transaction as the block should report it
  typedef struct packed {
    logic [ARR_W-1:0]   schedule;
    logic [CNT_W-1:0]   served;
    logic [TOTAL_W-1:0] total;
    logic [CNT_W-1:0]   dropped;
  } link_result_t;

  logic [QBITS-1:0] link_backlog [LINKS];
  ends_t            link_ends [LINKS];
  logic [CFG_W-1:0] links_cfg;
  link_result_t     awaited_results [SLOTS];
  int               rd_slot;
  int               wr_slot;
  int               errors;

  // Apply one input transaction to the mirrored state and work out its result
  function automatic link_result_t schedule_links(
    logic op, logic [IDX_W-1:0] idx, logic [NODE_W-1:0] na, logic [NODE_W-1:0] nb,
    logic [ARR_W-1:0] arr
  );
    link_result_t res;
    logic [ARR_W-1:0] cand;
    ends_t w;
    ends_t e;
    longint sum;
    int n;
    int winner;
    res = '0;
    n = (links_cfg > LINKS) ? LINKS : int'(links_cfg);
    if (op == OP_LOAD) begin
      link_ends[idx] = '{a: na, b: nb};
    end else begin
      // add arrivals on the links in use, drop on a full count
      cand = '0;
      for (int i = 0; i < n; i++) begin
        if (arr[i]) begin
          if (link_backlog[i] == QUEUE_FULL) res.dropped++;
          else link_backlog[i]++;
        end
        cand[i] = 1'b1;
      end
      // greedy rounds: longest backlog wins, lowest index on a tie
      while (cand != '0) begin
        winner = -1;
        for (int i = 0; i < n; i++) begin
          if (cand[i] && (winner < 0 || link_backlog[i] > link_backlog[winner])) winner = i;
        end
        res.schedule[winner] = 1'b1;
        w = link_ends[winner];
        for (int i = 0; i < n; i++) begin
          e = link_ends[i];
          if (cand[i] && (i == winner || e.a == w.a || e.a == w.b || e.b == w.a ||
                          e.b == w.b)) cand[i] = 1'b0;
        end
      end
      // serve one packet on each scheduled link that has one
      for (int i = 0; i < n; i++) begin
        if (res.schedule[i] && link_backlog[i] != '0) begin
          link_backlog[i]--;
          res.served++;
        end
      end
    end
    sum = 0;
    for (int i = 0; i < n; i++) sum += link_backlog[i];
    res.total = (sum > longint'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    link_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < LINKS; i++) link_backlog[i] = '0;
      links_cfg = '0;
      rd_slot   = 0;
      wr_slot   = 0;
    end else begin
      // compare the result transaction with the oldest prediction
      if (out_valid) begin
        if (wr_slot == rd_slot) begin
          $error("result transaction with nothing outstanding: schedule %h", out_schedule);
          errors++;
        end else begin
          want = awaited_results[rd_slot[1:0]];
          rd_slot++;
          if (out_schedule !== want.schedule) begin
            $error("out_schedule: expected %h, got %h", want.schedule, out_schedule);
            errors++;
          end
          if (out_served_count !== want.served) begin
            $error("out_served_count: expected %0d, got %0d", want.served, out_served_count);
            errors++;
          end
          if (out_total_queued !== want.total) begin
            $error("out_total_queued: expected %0d, got %0d", want.total, out_total_queued);
            errors++;
          end
          if (out_dropped !== want.dropped) begin
            $error("out_dropped: expected %0d, got %0d", want.dropped, out_dropped);
            errors++;
          end
        end
      end
      // track the link count register
      if (cfg_valid && cfg_ready) links_cfg = cfg_num_links;
      // predict each accepted input transaction
      if (start && !busy) begin
        if (wr_slot - rd_slot >= SLOTS) begin
          $error("too many transactions outstanding: %0d", wr_slot - rd_slot);
          errors++;
        end else begin
          awaited_results[wr_slot[1:0]] = schedule_links(in_op, in_link_index, in_node_a,
                                                         in_node_b, in_arrivals);
          wr_slot++;
        end
      end
    end
    fail_count <= errors;
    pending    <= wr_slot - rd_slot;
  end

endmodule

>>> bench/tb_top.sv
module tb_top
  import glqs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 200;
  localparam int FILL_CAP     = 150;
  localparam int FILL_DROPS   = 16;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_op;
  logic [IDX_W-1:0]   in_link_index;
  logic [NODE_W-1:0]  in_node_a;
  logic [NODE_W-1:0]  in_node_b;
  logic [ARR_W-1:0]   in_arrivals;
  logic               out_valid;
  logic [ARR_W-1:0]   out_schedule;
  logic [CNT_W-1:0]   out_served_count;
  logic [TOTAL_W-1:0] out_total_queued;
  logic [CNT_W-1:0]   out_dropped;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_num_links;

  int               fail_count;
  int               pending;
  int               idle_pct;
  int               quiet;
  int               drop_slots;
  logic [ARR_W-1:0] ends_loaded;

  greedy_longest_queue_link_scheduler_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_link_index    (in_link_index),
    .in_node_a        (in_node_a),
    .in_node_b        (in_node_b),
    .in_arrivals      (in_arrivals),
    .out_valid        (out_valid),
    .out_schedule     (out_schedule),
    .out_served_count (out_served_count),
    .out_total_queued (out_total_queued),
    .out_dropped      (out_dropped),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_num_links    (cfg_num_links)
  );

  glqs_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_link_index    (in_link_index),
    .in_node_a        (in_node_a),
    .in_node_b        (in_node_b),
    .in_arrivals      (in_arrivals),
    .out_valid        (out_valid),
    .out_schedule     (out_schedule),
    .out_served_count (out_served_count),
    .out_total_queued (out_total_queued),
    .out_dropped      (out_dropped),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_num_links    (cfg_num_links),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // End the run when no transaction of any kind moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Count slots that reported dropped arrivals
  always @(posedge clk) begin
    if (rst_n && out_valid && out_dropped != '0) drop_slots <= drop_slots + 1;
  end

  // Drive one input transaction and hold it until the block takes it
  task automatic send_item(logic op, logic [IDX_W-1:0] idx, logic [NODE_W-1:0] na,
                           logic [NODE_W-1:0] nb, logic [ARR_W-1:0] arr);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    start         = 1'b1;
    in_op         = op;
    in_link_index = idx;
    in_node_a     = na;
    in_node_b     = nb;
    in_arrivals   = arr;
    if (op == OP_LOAD) ends_loaded[idx] = 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_load(logic [IDX_W-1:0] idx, logic [NODE_W-1:0] na,
                           logic [NODE_W-1:0] nb);
    send_item(OP_LOAD, idx, na, nb, {$urandom, $urandom});
  endtask

  task automatic send_slot(logic [ARR_W-1:0] arr);
    send_item(OP_SLOT, IDX_W'($urandom), NODE_W'($urandom), NODE_W'($urandom), arr);
  endtask

  // Drop start and wait until every result is back
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk);
  endtask

  // Load any missing endpoints, then write the link count while idle
  task automatic set_links(int v);
    int lim;
    lim = (v > 64) ? 64 : v;
    for (int i = 0; i < lim; i++) begin
      if (!ends_loaded[i]) begin
        send_load(IDX_W'(i), NODE_W'($urandom_range(7)), NODE_W'($urandom_range(7)));
      end
    end
    settle();
    @(negedge clk);
    cfg_valid     = 1'b1;
    cfg_num_links = v[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One link count setting with a mix of reloads and slots
  task automatic run_setting(int v, int count);
    int n;
    logic [IDX_W-1:0] idx;
    logic [ARR_W-1:0] lo;
    logic [ARR_W-1:0] hi;
    logic [ARR_W-1:0] arr;
    set_links(v);
    n = (v > 64) ? 64 : v;
    repeat (count) begin
      if ($urandom_range(99) < 12) begin
        idx = (n == 0 || $urandom_range(3) == 0) ? IDX_W'($urandom_range(63))
                                                 : IDX_W'($urandom_range(n - 1));
        if ($urandom_range(1)) begin
          send_load(idx, NODE_W'($urandom_range(3)), NODE_W'($urandom_range(3)));
        end else begin
          send_load(idx, NODE_W'($urandom_range(31)), NODE_W'($urandom_range(31)));
        end
      end else begin
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        case ($urandom_range(3))
          0: arr = lo & hi;
          1: arr = lo | hi;
          2: arr = lo;
          default: arr = $urandom_range(1) ? '1 : '0;
        endcase
        send_slot(arr);
      end
    end
  endtask

  // Mostly small link counts, now and then the largest ones
  task automatic random_phase(int pct);
    idle_pct = pct;
    repeat (11) begin
      case ($urandom_range(9))
        0: run_setting($urandom_range(127, 65), 6);
        1: run_setting(64, 8);
        2: run_setting($urandom_range(40, 9), 20);
        3: run_setting($urandom_range(2, 0), 30);
        default: run_setting($urandom_range(8, 1), 90);
      endcase
    end
  endtask

  initial begin
    int filled;
    filled        = 0;
    start         = 1'b0;
    in_op         = OP_LOAD;
    in_link_index = '0;
    in_node_a     = '0;
    in_node_b     = '0;
    in_arrivals   = '0;
    cfg_valid     = 1'b0;
    cfg_num_links = '0;
    idle_pct      = 21;
    ends_loaded   = '0;
    rst_n         = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // no links in use: every arrival is ignored, nothing scheduled
    set_links(0);
    send_slot('1);
    send_load(IDX_W'(63), NODE_W'(31), NODE_W'(31));
    send_load(IDX_W'(0), NODE_W'(0), NODE_W'(31));
    send_load(IDX_W'(1), NODE_W'(31), NODE_W'(5));
    send_load(IDX_W'(2), NODE_W'(5), NODE_W'(6));
    send_load(IDX_W'(3), NODE_W'(7), NODE_W'(7));

    // four links: empty queues scheduled, ties, conflicts, unused arrival bits
    set_links(4);
    send_slot('0);
    send_slot('1);
    send_slot(64'h2);
    send_slot(64'hA);
    send_load(IDX_W'(2), NODE_W'(0), NODE_W'(0));
    send_slot(64'hF0F0_0000_0000_000C);

    // link count above the maximum, then at it
    set_links(127);
    send_slot('1);
    send_slot(64'h5555_5555_5555_5555);
    send_slot('0);
    set_links(65);
    send_slot(64'hAAAA_AAAA_AAAA_AAAA);
    set_links(64);
    send_slot(64'h8000_0000_0000_0000);

    random_phase(21);
    random_phase(83);
    random_phase(0);

    // star of three links sharing one node: one served per slot, counts climb
    send_load(IDX_W'(0), NODE_W'(7), NODE_W'(1));
    send_load(IDX_W'(1), NODE_W'(7), NODE_W'(2));
    send_load(IDX_W'(2), NODE_W'(7), NODE_W'(3));
    set_links(3);
    while (filled < FILL_CAP && drop_slots < FILL_DROPS) begin
      send_slot('1);
      filled++;
    end

    // totals with climbed counts hidden, then included
    set_links(0);
    send_load(IDX_W'(5), NODE_W'(1), NODE_W'(2));
    set_links(64);
    send_load(IDX_W'(5), NODE_W'(1), NODE_W'(2));

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
